// ----- design/fsha_pkg.sv -----
// shared types and constants for the frame statistics block
`default_nettype none
package fsha_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int SLOT_W       = 6;
  localparam int IDX_W        = 16;
  localparam int SUM_W        = 2 * SAMPLE_W;
  localparam int HIST_DEPTH   = 32;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int TOT_W        = SAMPLE_W + HIST_AW;
  localparam int SKIP_SAMPLES = 4;
  localparam int DIV_CNT_W    = $clog2(SAMPLE_W);
  localparam int ENTRY_W      = 3 * SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = {SAMPLE_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] MEAN_INIT     = SAMPLE_W'(3) << (SAMPLE_W - 2);
  localparam logic [SAMPLE_W-1:0] FRAME_LEN_RST = SAMPLE_W'(8192);
  localparam logic [TOT_W-1:0]    TOT_MEAN_RST  = TOT_W'(MEAN_INIT) << HIST_AW;
  localparam logic [TOT_W-1:0]    TOT_MIN_RST   = TOT_W'(FULL_SCALE) << HIST_AW;
  localparam logic [TOT_W-1:0]    TOT_MAX_RST   = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic tbl_read;
    logic div_init;
    logic div_step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/fsha_in_if.sv -----
// sample channel interface
`default_nettype none
interface fsha_in_if import fsha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [SLOT_W-1:0]   frame_slot;
  logic                last_sample;

  modport source (output valid, sample, frame_slot, last_sample, input ready);
  modport sink (input valid, sample, frame_slot, last_sample, output ready);
endinterface
`default_nettype wire

// ----- design/fsha_out_if.sv -----
// result channel interface
`default_nettype none
interface fsha_out_if import fsha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] frame_mean;
  logic [SAMPLE_W-1:0] frame_min;
  logic [SAMPLE_W-1:0] frame_max;
  logic [SAMPLE_W-1:0] history_mean_avg;
  logic [SAMPLE_W-1:0] history_min_avg;
  logic [SAMPLE_W-1:0] history_max_avg;

  modport source (output valid, frame_mean, frame_min, frame_max, history_mean_avg,
                  history_min_avg, history_max_avg, input ready);
  modport sink (input valid, frame_mean, frame_min, frame_max, history_mean_avg,
                history_min_avg, history_max_avg, output ready);
endinterface
`default_nettype wire

// ----- design/frame_stats_with_history_average.sv -----
// top level of the frame statistics block
// Samples that do not end a frame are taken one per cycle while the block is idle.
// A sample marked last occupies the block while it is taken, the divider is set up,
// the bit-serial restoring divider forms the frame mean, and a final step updates
// the 32-entry history memory and its running totals and loads the result register.
// That last step waits while an earlier result has not been taken. The user must write
// frame length through cfg_we / cfg_wdata only while idle; the block does not check.
`default_nettype none
module frame_stats_with_history_average import fsha_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  fsha_in_if.sink                  in_if,
  fsha_out_if.source               out_if
);
  ctl_cmd_t   cmd;
  dp_status_t status;

  fsha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last_sample),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fsha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_if.sample),
    .in_slot   (in_if.frame_slot),
    .cmd       (cmd),
    .status    (status),
    .out_if    (out_if)
  );
endmodule
`default_nettype wire

// ----- design/fsha_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module fsha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- design/fsha_ctrl.sv -----
// controller state machine for the frame statistics block
`default_nettype none
module fsha_ctrl import fsha_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_last,
  output      logic       in_ready,
  input  wire dp_status_t status,
  output      ctl_cmd_t   cmd
);
  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          cmd.tbl_read = 1'b1;
          state_nxt    = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- design/fsha_dp.sv -----
// datapath: accumulators, serial divider, history tables and result register
`default_nettype none
module fsha_dp import fsha_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire ctl_cmd_t            cmd,
  output      dp_status_t          status,
  fsha_out_if.source               out_if
);
  logic [SAMPLE_W-1:0]  frame_len_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SAMPLE_W-1:0]  min_r;
  logic [SAMPLE_W-1:0]  max_r;
  logic [HIST_AW-1:0]   slot_r;
  logic                 slot_ok_r;
  logic [HIST_DEPTH-1:0] valid_r;
  logic [TOT_W-1:0]     tot_mean_r, tot_min_r, tot_max_r;
  logic [SAMPLE_W-1:0]  rem_r, quo_r;
  logic                 sat_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  o_mean_r, o_min_r, o_max_r, o_hmean_r, o_hmin_r, o_hmax_r;

  logic                 counted;
  logic [SLOT_W-1:0]    slot_m1;
  logic                 slot_ok;
  logic [SAMPLE_W:0]    r2, diff;
  logic                 q_bit;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [SAMPLE_W-1:0]  old_mean, old_min, old_max, mean;
  logic [TOT_W-1:0]     tot_mean_nxt, tot_min_nxt, tot_max_nxt;
  logic                 tbl_we;

  // frame accumulation
  assign counted = (idx_r >= IDX_W'(SKIP_SAMPLES)) && (idx_r < IDX_W'(frame_len_r));
  assign slot_m1 = in_slot - SLOT_W'(1);
  assign slot_ok = (in_slot != '0) && (in_slot <= SLOT_W'(HIST_DEPTH));

  // one quotient bit per step
  assign r2    = {rem_r, quo_r[SAMPLE_W-1]};
  assign diff  = r2 - {1'b0, frame_len_r};
  assign q_bit = (r2 >= {1'b0, frame_len_r});
  assign mean  = sat_r ? FULL_SCALE : quo_r;

  assign status.div_done = (cnt_r == DIV_CNT_W'(SAMPLE_W - 1));
  assign status.out_free = !out_valid_r || out_if.ready;

  // history tables, entries not yet written read as reset contents
  assign tbl_we = cmd.commit && slot_ok_r;

  fsha_ram #(.WIDTH(ENTRY_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot_r),
    .wdata ({mean, min_r, max_r}),
    .re    (cmd.tbl_read),
    .raddr (slot_m1[HIST_AW-1:0]),
    .rdata (rd_entry)
  );

  always_comb begin
    if (valid_r[slot_r]) begin
      old_mean = rd_entry[3*SAMPLE_W-1:2*SAMPLE_W];
      old_min  = rd_entry[2*SAMPLE_W-1:SAMPLE_W];
      old_max  = rd_entry[SAMPLE_W-1:0];
    end else begin
      old_mean = MEAN_INIT;
      old_min  = FULL_SCALE;
      old_max  = '0;
    end
    if (slot_ok_r) begin
      tot_mean_nxt = tot_mean_r - TOT_W'(old_mean) + TOT_W'(mean);
      tot_min_nxt  = tot_min_r - TOT_W'(old_min) + TOT_W'(min_r);
      tot_max_nxt  = tot_max_r - TOT_W'(old_max) + TOT_W'(max_r);
    end else begin
      tot_mean_nxt = tot_mean_r;
      tot_min_nxt  = tot_min_r;
      tot_max_nxt  = tot_max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
      idx_r       <= '0;
      sum_r       <= '0;
      min_r       <= FULL_SCALE;
      max_r       <= '0;
      valid_r     <= '0;
      tot_mean_r  <= TOT_MEAN_RST;
      tot_min_r   <= TOT_MIN_RST;
      tot_max_r   <= TOT_MAX_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_len_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (counted) begin
          sum_r <= sum_r + SUM_W'(in_sample);
          if (in_sample > max_r) begin
            max_r <= in_sample;
          end
          if (in_sample != '0 && in_sample < min_r) begin
            min_r <= in_sample;
          end
        end
        if (idx_r != {IDX_W{1'b1}}) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (cmd.div_init) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        tot_mean_r  <= tot_mean_nxt;
        tot_min_r   <= tot_min_nxt;
        tot_max_r   <= tot_max_nxt;
        if (slot_ok_r) begin
          valid_r[slot_r] <= 1'b1;
        end
        idx_r <= '0;
        sum_r <= '0;
        min_r <= FULL_SCALE;
        max_r <= '0;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.tbl_read) begin
      slot_r    <= slot_m1[HIST_AW-1:0];
      slot_ok_r <= slot_ok;
    end
    if (cmd.div_init) begin
      sat_r <= (sum_r[SUM_W-1:SAMPLE_W] >= frame_len_r);
      rem_r <= sum_r[SUM_W-1:SAMPLE_W];
      quo_r <= sum_r[SAMPLE_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? diff[SAMPLE_W-1:0] : r2[SAMPLE_W-1:0];
      quo_r <= {quo_r[SAMPLE_W-2:0], q_bit};
    end
    if (cmd.commit) begin
      o_mean_r  <= mean;
      o_min_r   <= min_r;
      o_max_r   <= max_r;
      o_hmean_r <= tot_mean_nxt[HIST_AW +: SAMPLE_W];
      o_hmin_r  <= tot_min_nxt[HIST_AW +: SAMPLE_W];
      o_hmax_r  <= tot_max_nxt[HIST_AW +: SAMPLE_W];
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.frame_mean       = o_mean_r;
  assign out_if.frame_min        = o_min_r;
  assign out_if.frame_max        = o_max_r;
  assign out_if.history_mean_avg = o_hmean_r;
  assign out_if.history_min_avg  = o_hmin_r;
  assign out_if.history_max_avg  = o_hmax_r;
endmodule
`default_nettype wire
